// ----- design/fpba_pkg.sv -----
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and defaults of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Default table depth and size width
  localparam int unsigned MaxBlocksDef = 16;
  localparam int unsigned SizeBitsDef  = 16;

  // Fixed field widths
  localparam int unsigned KindW   = 2;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned FidxW   = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned OffsetW = 20;
  localparam int unsigned PolicyW = 2;

  // Request kinds
  localparam logic [KindW-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KindW-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KindW-1:0] KIND_FREE  = 2'd2;

  // Fit policies
  localparam logic [PolicyW-1:0] POL_BEST  = 2'd0;
  localparam logic [PolicyW-1:0] POL_FIRST = 2'd1;
  localparam logic [PolicyW-1:0] POL_WORST = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] STAT_OK       = 3'd0;
  localparam logic [StatusW-1:0] STAT_NOFIT    = 3'd1;
  localparam logic [StatusW-1:0] STAT_FULL     = 3'd2;
  localparam logic [StatusW-1:0] STAT_USED_GT  = 3'd3;
  localparam logic [StatusW-1:0] STAT_BAD_IDX  = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [FieldW-1:0] block_size;
    logic [FieldW-1:0] block_used;
    logic [FieldW-1:0] request_size;
    logic [FidxW-1:0]  free_index;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  chosen_index;
    logic [OffsetW-1:0] chosen_offset;
    logic [FieldW-1:0]  free_after;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_ALLOC_END,
    S_FREE_RD,
    S_FREE_END,
    S_NOP
  } state_e;

  // Datapath operation for the current cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_SCAN,
    OP_ALLOC_END,
    OP_FREE_RD,
    OP_FREE_END,
    OP_NOP_END
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic bad_index;
  } stat_t;

endpackage

// ----- design/fpba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: steps each request through load, scan, free or no-op phases.
// ----------------------------------------------------------------------------
module fpba_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic [fpba_pkg::KindW-1:0]     kind_i,
  input  fpba_pkg::stat_t                stat_i,
  output fpba_pkg::cmd_t                 cmd_o,
  output logic                           busy
);

  fpba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = fpba_pkg::OP_NONE;
    busy       = 1'b1;
    unique case (state_q)
      fpba_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.op = fpba_pkg::OP_CAPTURE;
          unique case (kind_i)
            fpba_pkg::KIND_LOAD:  state_d = fpba_pkg::S_LOAD;
            fpba_pkg::KIND_ALLOC: state_d = fpba_pkg::S_SCAN;
            fpba_pkg::KIND_FREE:  state_d = fpba_pkg::S_FREE_RD;
            default:              state_d = fpba_pkg::S_NOP;
          endcase
        end
      end
      fpba_pkg::S_LOAD: begin
        cmd_o.op = fpba_pkg::OP_LOAD;
        state_d  = fpba_pkg::S_IDLE;
      end
      fpba_pkg::S_SCAN: begin
        cmd_o.op = fpba_pkg::OP_SCAN;
        if (stat_i.scan_done) begin
          state_d = fpba_pkg::S_ALLOC_END;
        end
      end
      fpba_pkg::S_ALLOC_END: begin
        cmd_o.op = fpba_pkg::OP_ALLOC_END;
        state_d  = fpba_pkg::S_IDLE;
      end
      fpba_pkg::S_FREE_RD: begin
        cmd_o.op = fpba_pkg::OP_FREE_RD;
        state_d  = stat_i.bad_index ? fpba_pkg::S_IDLE : fpba_pkg::S_FREE_END;
      end
      fpba_pkg::S_FREE_END: begin
        cmd_o.op = fpba_pkg::OP_FREE_END;
        state_d  = fpba_pkg::S_IDLE;
      end
      fpba_pkg::S_NOP: begin
        cmd_o.op = fpba_pkg::OP_NOP_END;
        state_d  = fpba_pkg::S_IDLE;
      end
      default: begin
        state_d = fpba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/fpba_dp.sv -----
// ----------------------------------------------------------------------------
// fpba_dp
// Block tables, scan compare unit, policy register and result register.
// ----------------------------------------------------------------------------
module fpba_dp #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::MaxBlocksDef,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpba_pkg::req_t                req_i,
  input  logic                          cfg_valid_i,
  input  logic [fpba_pkg::PolicyW-1:0]  cfg_data_i,
  input  fpba_pkg::cmd_t                cmd_i,
  output fpba_pkg::stat_t               stat_o,
  output fpba_pkg::res_t                result_o,
  output logic                          done_o
);

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned XW = (CW > fpba_pkg::FidxW) ? CW : fpba_pkg::FidxW;
  localparam int unsigned OW = fpba_pkg::OffsetW;

  // Tables (contents undefined until loaded)
  logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] used_mem [MAX_BLOCKS];
  logic [OW-1:0]        off_mem  [MAX_BLOCKS];

  logic [SIZE_BITS-1:0] rsize_q, rused_q;
  logic [OW-1:0]        roff_q;

  // Captured request
  logic [SIZE_BITS-1:0]       bsize_q, bused_q, req_q;
  logic [fpba_pkg::FidxW-1:0] fidx_q;

  // Control state
  logic [CW-1:0]                count_q, count_d;
  logic [OW-1:0]                next_q, next_d;
  logic [fpba_pkg::PolicyW-1:0] policy_q;
  logic [CW-1:0]                scan_q, scan_d;
  logic                         rd_pend_q, rd_pend_d;
  logic                         found_q, found_d;
  logic                         done_q, done_d;

  // Scan bookkeeping
  logic [IW-1:0]        rd_idx_q;
  logic [IW-1:0]        pick_idx_q;
  logic [SIZE_BITS-1:0] pick_free_q, pick_used_q;
  logic [OW-1:0]        pick_off_q;

  fpba_pkg::res_t res_q, res_d;

  logic                 scan_done, bad_index, full, used_gt;
  logic                 rd_en, we_all, we_used, take, fits, sel;
  logic [IW-1:0]        raddr, waddr;
  logic [SIZE_BITS-1:0] wused, avail;

  assign scan_done = (scan_q == count_q);
  assign bad_index = (XW'(fidx_q) >= XW'(count_q));
  assign full      = (count_q == CW'(MAX_BLOCKS));
  assign used_gt   = (bused_q > bsize_q);

  assign stat_o.scan_done = scan_done;
  assign stat_o.bad_index = bad_index;

  // Candidate evaluation on the entry read in the previous cycle
  assign avail = rsize_q - rused_q;
  assign fits  = (avail >= req_q);

  always_comb begin
    unique case (policy_q)
      fpba_pkg::POL_FIRST: sel = !found_q;
      fpba_pkg::POL_BEST:  sel = !found_q || (pick_free_q >= avail);
      fpba_pkg::POL_WORST: sel = !found_q || (pick_free_q <= avail);
      default:             sel = 1'b0;
    endcase
  end

  assign take = rd_pend_q && fits && sel;

  always_comb begin
    count_d   = count_q;
    next_d    = next_q;
    scan_d    = scan_q;
    found_d   = found_q || take;
    rd_pend_d = 1'b0;
    rd_en     = 1'b0;
    raddr     = scan_q[IW-1:0];
    we_all    = 1'b0;
    we_used   = 1'b0;
    waddr     = count_q[IW-1:0];
    wused     = bused_q;
    done_d    = 1'b0;
    res_d     = '0;
    unique case (cmd_i.op)
      fpba_pkg::OP_CAPTURE: begin
        scan_d  = '0;
        found_d = 1'b0;
      end
      fpba_pkg::OP_LOAD: begin
        done_d = 1'b1;
        if (used_gt) begin
          res_d.status = fpba_pkg::STAT_USED_GT;
        end else if (full) begin
          res_d.status = fpba_pkg::STAT_FULL;
        end else begin
          we_all              = 1'b1;
          count_d             = count_q + CW'(1);
          next_d              = next_q + OW'(bsize_q);
          res_d.status        = fpba_pkg::STAT_OK;
          res_d.chosen_index  = fpba_pkg::IndexW'(count_q);
          res_d.chosen_offset = next_q;
          res_d.free_after    = fpba_pkg::FieldW'(bsize_q - bused_q);
        end
      end
      fpba_pkg::OP_SCAN: begin
        if (!scan_done) begin
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          scan_d    = scan_q + CW'(1);
        end
      end
      fpba_pkg::OP_ALLOC_END: begin
        done_d = 1'b1;
        if (found_q) begin
          we_used             = 1'b1;
          waddr               = pick_idx_q;
          wused               = pick_used_q + req_q;
          res_d.status        = fpba_pkg::STAT_OK;
          res_d.chosen_index  = fpba_pkg::IndexW'(pick_idx_q);
          res_d.chosen_offset = pick_off_q;
          res_d.free_after    = fpba_pkg::FieldW'(pick_free_q - req_q);
        end else begin
          res_d.status = fpba_pkg::STAT_NOFIT;
        end
      end
      fpba_pkg::OP_FREE_RD: begin
        raddr = IW'(fidx_q);
        if (bad_index) begin
          done_d       = 1'b1;
          res_d.status = fpba_pkg::STAT_BAD_IDX;
        end else begin
          rd_en = 1'b1;
        end
      end
      fpba_pkg::OP_FREE_END: begin
        done_d              = 1'b1;
        we_used             = 1'b1;
        waddr               = IW'(fidx_q);
        wused               = '0;
        res_d.status        = fpba_pkg::STAT_OK;
        res_d.chosen_index  = fpba_pkg::IndexW'(fidx_q);
        res_d.chosen_offset = roff_q;
        res_d.free_after    = fpba_pkg::FieldW'(rsize_q);
      end
      fpba_pkg::OP_NOP_END: begin
        done_d       = 1'b1;
        res_d.status = fpba_pkg::STAT_OK;
      end
      default: begin
      end
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (we_all) begin
      size_mem[waddr] <= bsize_q;
      off_mem[waddr]  <= next_q;
    end
    if (we_all || we_used) begin
      used_mem[waddr] <= wused;
    end
    if (rd_en) begin
      rsize_q <= size_mem[raddr];
      rused_q <= used_mem[raddr];
      roff_q  <= off_mem[raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == fpba_pkg::OP_CAPTURE) begin
      bsize_q <= SIZE_BITS'(req_i.block_size);
      bused_q <= SIZE_BITS'(req_i.block_used);
      req_q   <= SIZE_BITS'(req_i.request_size);
      fidx_q  <= req_i.free_index;
    end
    if (rd_en) begin
      rd_idx_q <= raddr;
    end
    if (take) begin
      pick_idx_q  <= rd_idx_q;
      pick_free_q <= avail;
      pick_used_q <= rused_q;
      pick_off_q  <= roff_q;
    end
    if (done_d) begin
      res_q <= res_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      next_q    <= '0;
      policy_q  <= fpba_pkg::POL_BEST;
      scan_q    <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      next_q    <= next_d;
      scan_q    <= scan_d;
      rd_pend_q <= rd_pend_d;
      found_q   <= found_d;
      done_q    <= done_d;
      if (cfg_valid_i) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

  // done_d is never set in idle and every finishing state returns to idle, so strobes never abut
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe on consecutive cycles");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("block count moved by other than one");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status != fpba_pkg::STAT_OK)) |->
      ((res_q.chosen_index == '0) && (res_q.chosen_offset == '0) &&
       (res_q.free_after == '0)))
    else $error("failed result carries nonzero fields");

endmodule

// ----- design/fit_policy_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block allocator with first, best and worst fit selection.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low; busy then stays
// high until the request is finished. Every request gives exactly one
// result, shown on result_o for a single cycle while done_o is high. There
// is no back pressure: the receiver must take the result in that cycle. The
// result register is separate from the sequencer, so the next request may
// be issued in the same cycle that the previous result is on the port.
// Steps from one accepted request to the next: load is capture then load;
// free is capture, index read, then free write (no write when the index is
// out of range); an unknown kind is capture then a no-op end; allocate is
// capture, a scan of all loaded blocks, then the allocate write. The scan
// grows with the block count: the block table has a single registered read
// port and the compare unit looks at one block per cycle, in table order.
// The fit policy register is written through cfg_valid_i/cfg_data_i and is
// always ready; write it only while no request is in flight. Policy code 3
// makes every allocate report no fit. On a tie under best or worst fit the
// later block wins. Table contents are not cleared at reset; only entries
// below the block count are ever read.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::MaxBlocksDef,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          start,
  output logic                          busy,
  input  fpba_pkg::req_t                item_i,
  // result side
  output logic                          done_o,
  output fpba_pkg::res_t                result_o,
  // policy register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fpba_pkg::PolicyW-1:0]  cfg_data_i
);

  fpba_pkg::cmd_t  cmd;
  fpba_pkg::stat_t stat;

  // Policy writes are always accepted
  assign cfg_ready_o = 1'b1;

  // Sequencer: decodes the request kind and steps through the phases
  fpba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (item_i.kind),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Tables, scan unit and result register
  fpba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule

// ----- dv/fpba_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// fpba_tb_pkg
// Scoreboard for the fit policy block allocator: it predicts each request's
// result from a private copy of the block table and checks the results.
// ----------------------------------------------------------------------------
package fpba_tb_pkg;

  // Codes the design leaves without a name
  localparam logic [fpba_pkg::KindW-1:0]   KIND_NOP   = 2'd3;
  localparam logic [fpba_pkg::PolicyW-1:0] POL_NONE   = 2'd3;
  localparam int unsigned                  TableDepth = fpba_pkg::MaxBlocksDef;

  class alloc_scoreboard;
    logic [fpba_pkg::FieldW-1:0]  size_tab [TableDepth];
    logic [fpba_pkg::FieldW-1:0]  used_tab [TableDepth];
    logic [fpba_pkg::OffsetW-1:0] off_tab  [TableDepth];
    int unsigned                  blocks;
    logic [fpba_pkg::OffsetW-1:0] next_off;
    logic [fpba_pkg::PolicyW-1:0] policy;
    fpba_pkg::res_t               expected_q [$];
    int unsigned                  errors;
    int unsigned                  checked;
    int unsigned                  status_seen [8];

    function new();
      blocks   = 0;
      next_off = '0;
      policy   = fpba_pkg::POL_BEST;
      errors   = 0;
      checked  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_policy(logic [fpba_pkg::PolicyW-1:0] p);
      policy = p;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // free space of a random loaded block, for requests that should fit
    function logic [fpba_pkg::FieldW-1:0] some_free();
      int unsigned i;
      if (blocks == 0) return '0;
      i = $urandom_range(0, blocks - 1);
      return size_tab[i] - used_tab[i];
    endfunction

    // table update and expected result of one accepted request
    function fpba_pkg::res_t apply_request(fpba_pkg::req_t r);
      fpba_pkg::res_t               res;
      logic [fpba_pkg::FieldW-1:0]  f;
      logic [fpba_pkg::FieldW-1:0]  pick_free;
      logic [fpba_pkg::OffsetW-1:0] wide_size;
      int unsigned                  pick;
      bit                           found;
      res       = '0;
      pick_free = '0;
      pick      = 0;
      found     = 1'b0;
      case (r.kind)
        fpba_pkg::KIND_LOAD: begin
          if (r.block_used > r.block_size) begin
            res.status = fpba_pkg::STAT_USED_GT;
          end else if (blocks >= TableDepth) begin
            res.status = fpba_pkg::STAT_FULL;
          end else begin
            size_tab[blocks]  = r.block_size;
            used_tab[blocks]  = r.block_used;
            off_tab[blocks]   = next_off;
            res.status        = fpba_pkg::STAT_OK;
            res.chosen_index  = blocks[fpba_pkg::IndexW-1:0];
            res.chosen_offset = next_off;
            res.free_after    = r.block_size - r.block_used;
            wide_size         = r.block_size;
            next_off          = next_off + wide_size;
            blocks++;
          end
        end
        fpba_pkg::KIND_ALLOC: begin
          if (policy != POL_NONE) begin
            for (int unsigned i = 0; i < blocks; i++) begin
              f = size_tab[i] - used_tab[i];
              if (f < r.request_size) continue;
              if (policy == fpba_pkg::POL_FIRST) begin
                found     = 1'b1;
                pick      = i;
                pick_free = f;
                break;
              end
              // later block wins a tie
              if (!found || (policy == fpba_pkg::POL_BEST && pick_free >= f) ||
                  (policy == fpba_pkg::POL_WORST && pick_free <= f)) begin
                found     = 1'b1;
                pick      = i;
                pick_free = f;
              end
            end
          end
          if (!found) begin
            res.status = fpba_pkg::STAT_NOFIT;
          end else begin
            used_tab[pick]    = used_tab[pick] + r.request_size;
            res.status        = fpba_pkg::STAT_OK;
            res.chosen_index  = pick[fpba_pkg::IndexW-1:0];
            res.chosen_offset = off_tab[pick];
            res.free_after    = pick_free - r.request_size;
          end
        end
        fpba_pkg::KIND_FREE: begin
          if (r.free_index >= blocks) begin
            res.status = fpba_pkg::STAT_BAD_IDX;
          end else begin
            used_tab[r.free_index] = '0;
            res.status        = fpba_pkg::STAT_OK;
            res.chosen_index  = r.free_index;
            res.chosen_offset = off_tab[r.free_index];
            res.free_after    = size_tab[r.free_index];
          end
        end
        default: res = '0;
      endcase
      return res;
    endfunction

    function void note_request(fpba_pkg::req_t r);
      expected_q.push_back(apply_request(r));
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               checked, what, got, want);
      errors++;
    endtask

    task check_result(fpba_pkg::res_t got);
      fpba_pkg::res_t want;
      checked++;
      status_seen[got.status]++;
      if (expected_q.size() == 0) begin
        report("with no request outstanding", got, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report("status", got.status, want.status);
      if (got.chosen_index !== want.chosen_index)
        report("chosen_index", got.chosen_index, want.chosen_index);
      if (got.chosen_offset !== want.chosen_offset)
        report("chosen_offset", got.chosen_offset, want.chosen_offset);
      if (got.free_after !== want.free_after)
        report("free_after", got.free_after, want.free_after);
    endtask
  endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the fit policy block allocator: directed corner requests, then
// random phases under every fit policy, with bursty request traffic. Every
// result is checked against the scoreboard's own table model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake of any kind before the run is declared hung;
  // the slowest request is a full-table scan after the longest gap between bursts
  localparam int unsigned HangLimit   = 2000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseItems  = 220;
  localparam int unsigned NoneItems   = 40;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           start       = 1'b0;
  logic           busy;
  fpba_pkg::req_t item        = '0;
  logic           done_o;
  fpba_pkg::res_t result_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [fpba_pkg::PolicyW-1:0] cfg_data_i = fpba_pkg::POL_BEST;

  fpba_tb_pkg::alloc_scoreboard sb;
  int unsigned     hang_cycles;
  int unsigned     sent;
  int unsigned     directed;

  fit_policy_block_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Monitor: everything is sampled at the rising edge, while the block's
  // outputs still hold their pre-edge values. The result is checked before
  // a request taken in the same cycle is predicted; the result always
  // belongs to an older request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(result_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_policy(cfg_data_i);
      if (start && !busy) sb.note_request(item);
    end
  end

  // Hang detector: any request, result or register write resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HangLimit) begin
      $display("Timeout: no handshake for %0d cycles", HangLimit);
      $display("FAIL");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // Present one request from a falling edge until the block takes it.
  // Returns at the falling edge after acceptance with start still high, so
  // back-to-back requests keep start asserted without a dip.
  task automatic send_request(input fpba_pkg::req_t r);
    bit taken;
    item  = r;
    start = 1'b1;
    do begin
      @(posedge clk_i);
      taken = !busy;
      @(negedge clk_i);
    end while (!taken);
    sent++;
  endtask

  task automatic drive_item(input logic [fpba_pkg::KindW-1:0] k,
                            input int unsigned bsize,
                            input int unsigned bused, input int unsigned rsize,
                            input int unsigned fidx);
    fpba_pkg::req_t r;
    r.kind         = k;
    r.block_size   = bsize[fpba_pkg::FieldW-1:0];
    r.block_used   = bused[fpba_pkg::FieldW-1:0];
    r.request_size = rsize[fpba_pkg::FieldW-1:0];
    r.free_index   = fidx[fpba_pkg::FidxW-1:0];
    send_request(r);
  endtask

  // Policy writes only with the block idle: no request outstanding and
  // busy low. Every request returns a result, so an empty scoreboard means
  // nothing is in flight.
  task automatic write_policy(input logic [fpba_pkg::PolicyW-1:0] p);
    bit taken;
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = p;
    do begin
      @(posedge clk_i);
      taken = cfg_ready_o;
      @(negedge clk_i);
    end while (!taken);
    cfg_valid_i = 1'b0;
  endtask

  // Random request. Allocates dominate; about half of them ask for an amount
  // taken from a live block so that exact fits and ties come up often.
  // Fields a kind ignores stay random so every bit toggles.
  function automatic fpba_pkg::req_t rand_request();
    fpba_pkg::req_t r;
    int unsigned    roll;
    int unsigned    sz;
    r.kind         = fpba_tb_pkg::KIND_NOP;
    r.block_size   = fpba_pkg::FieldW'($urandom_range(0, 65535));
    r.block_used   = fpba_pkg::FieldW'($urandom_range(0, 65535));
    r.request_size = fpba_pkg::FieldW'($urandom_range(0, 65535));
    r.free_index   = fpba_pkg::FidxW'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      r.kind = fpba_pkg::KIND_LOAD;
      case ($urandom_range(0, 3))
        0:       sz = $urandom_range(0, 15);
        1, 2:    sz = $urandom_range(0, 4095);
        default: sz = $urandom_range(0, 65535);
      endcase
      r.block_size = sz[fpba_pkg::FieldW-1:0];
      // one load in eight claims more used space than the block holds
      if ($urandom_range(0, 7) == 0 && sz < 65535)
        r.block_used = fpba_pkg::FieldW'($urandom_range(sz + 1, 65535));
      else
        r.block_used = fpba_pkg::FieldW'($urandom_range(0, sz));
    end else if (roll < 70) begin
      r.kind = fpba_pkg::KIND_ALLOC;
      case ($urandom_range(0, 3))
        0:       r.request_size = fpba_pkg::FieldW'($urandom_range(0, 63));
        1:       r.request_size = sb.some_free();
        2:       r.request_size = fpba_pkg::FieldW'(sb.some_free() - $urandom_range(0, 3));
        default: r.request_size = fpba_pkg::FieldW'($urandom_range(0, 2047));
      endcase
    end else if (roll < 92) begin
      r.kind = fpba_pkg::KIND_FREE;
    end
    return r;
  endfunction

  initial begin
    logic [fpba_pkg::PolicyW-1:0] pol;
    int unsigned                  n_items;
    int unsigned                  burst_left;
    bit                           bursty;

    sb       = new();
    sent     = 0;
    directed = 0;

    // reset: held low from time zero, released on a falling edge
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- Directed part, reset policy (best fit) -------------------------
    // empty table: allocate finds nothing, frees are out of range
    drive_item(fpba_pkg::KIND_ALLOC, 0, 0, 0, 0);
    drive_item(fpba_pkg::KIND_FREE, 0, 0, 0, 0);
    drive_item(fpba_pkg::KIND_FREE, 0, 0, 0, 15);
    drive_item(fpba_tb_pkg::KIND_NOP, 0, 0, 0, 0);
    // used over size is rejected, also at the top of the range
    drive_item(fpba_pkg::KIND_LOAD, 0, 1, 0, 0);
    drive_item(fpba_pkg::KIND_LOAD, 65534, 65535, 0, 0);
    // size extremes, a fully used block, and two equal free amounts
    drive_item(fpba_pkg::KIND_LOAD, 0, 0, 0, 0);
    drive_item(fpba_pkg::KIND_LOAD, 65535, 0, 0, 0);
    drive_item(fpba_pkg::KIND_LOAD, 65535, 65535, 0, 0);
    drive_item(fpba_pkg::KIND_LOAD, 100, 20, 0, 0);
    drive_item(fpba_pkg::KIND_LOAD, 100, 20, 0, 0);
    drive_item(fpba_pkg::KIND_LOAD, 300, 100, 0, 0);
    // best fit ties: the later block must be picked
    drive_item(fpba_pkg::KIND_ALLOC, 0, 0, 80, 0);
    drive_item(fpba_pkg::KIND_ALLOC, 0, 0, 0, 0);
    // largest request fits once, then no more
    drive_item(fpba_pkg::KIND_ALLOC, 0, 0, 65535, 0);
    drive_item(fpba_pkg::KIND_ALLOC, 0, 0, 65535, 0);
    drive_item(fpba_pkg::KIND_ALLOC, 0, 0, 200, 0);
    // free a loaded block, one just past the count, and the last one
    drive_item(fpba_pkg::KIND_FREE, 0, 0, 0, 1);
    drive_item(fpba_pkg::KIND_FREE, 0, 0, 0, 6);
    drive_item(fpba_pkg::KIND_FREE, 0, 0, 0, 5);
    drive_item(fpba_pkg::KIND_ALLOC, 0, 0, 1, 0);
    // unknown kind with every other field at its maximum
    drive_item(fpba_tb_pkg::KIND_NOP, 65535, 65535, 65535, 15);
    directed = sent;

    // ---- Random phases --------------------------------------------------
    // Policy order walks first, worst and best fit; two short phases run
    // with the undefined code. The table is never cleared, so early phases
    // see a partly filled table and later ones a full one.
    burst_left = 0;
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph == 4 || ph == 9) begin
        pol     = fpba_tb_pkg::POL_NONE;
        n_items = NoneItems;
      end else begin
        case (ph % 3)
          0:       pol = fpba_pkg::POL_FIRST;
          1:       pol = fpba_pkg::POL_WORST;
          default: pol = fpba_pkg::POL_BEST;
        endcase
        n_items = PhaseItems;
      end
      write_policy(pol);
      // every third phase runs without any gap
      bursty = (ph % 3 != 2);
      for (int unsigned k = 0; k < n_items; k++) begin
        if (bursty && burst_left == 0) begin
          start = 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
          burst_left = $urandom_range(1, 30);
        end
        send_request(rand_request());
        if (burst_left != 0) burst_left--;
      end
    end
    start = 1'b0;

    // drain: wait for every outstanding result, then idle for DrainCycles
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d requests (%0d directed) under best, first, worst and undefined policy",
             sent, directed);
    $display("Results: ok %0d, no fit %0d, full %0d, used>size %0d, bad index %0d, errors %0d",
             sb.status_seen[fpba_pkg::STAT_OK], sb.status_seen[fpba_pkg::STAT_NOFIT],
             sb.status_seen[fpba_pkg::STAT_FULL], sb.status_seen[fpba_pkg::STAT_USED_GT],
             sb.status_seen[fpba_pkg::STAT_BAD_IDX], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fpba_pkg.sv
design/fpba_ctrl.sv
design/fpba_dp.sv
design/fit_policy_block_allocator_unit.sv
dv/fpba_tb_pkg.sv
dv/tb_top.sv
